### hdl/itp_pkg.sv
`default_nettype none

package itp_pkg;

    localparam int CELL_W_DEF  = 64;
    localparam int CELL_H_DEF  = 32;
    localparam int TILES_X_DEF = 16;
    localparam int TILES_Y_DEF = 16;

    localparam int POS_W     = 12;
    localparam int COORD_W   = 4;
    localparam int CORNER_W  = 3;
    localparam int CFG_IDX_W = 4;
    localparam int POS_SPAN  = 1 << POS_W;

    // biased pixel offset: offset plus a whole number of cells, always positive
    localparam int DIV_W = POS_W + 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X = 4'd0,
        REG_ORIGIN_Y = 4'd1
    } cfg_reg_t;

    typedef enum logic {
        OP_CLICK = 1'b0,
        OP_READ  = 1'b1
    } op_t;

    typedef enum logic [CORNER_W-1:0] {
        CORNER_INSIDE = 3'd0,
        CORNER_LT     = 3'd1,
        CORNER_RT     = 3'd2,
        CORNER_LB     = 3'd3,
        CORNER_RB     = 3'd4
    } corner_t;

endpackage

`default_nettype wire

### hdl/itp_channels.sv
`default_nettype none

interface itp_cfg_if
    import itp_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [POS_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface itp_item_if
    import itp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               op;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [COORD_W-1:0] query_x;
    logic [COORD_W-1:0] query_y;

    modport source (output valid, output op, output pos_x, output pos_y,
                    output query_x, output query_y, input ready);
    modport sink   (input valid, input op, input pos_x, input pos_y,
                    input query_x, input query_y, output ready);
endinterface

interface itp_result_if
    import itp_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                hit;
    logic [COORD_W-1:0]  base_x;
    logic [COORD_W-1:0]  base_y;
    logic [CORNER_W-1:0] corner;
    logic [COORD_W-1:0]  target_x;
    logic [COORD_W-1:0]  target_y;
    logic                marked;

    modport source (output valid, output hit, output base_x, output base_y, output corner,
                    output target_x, output target_y, output marked, input ready);
    modport sink   (input valid, input hit, input base_x, input base_y, input corner,
                    input target_x, input target_y, input marked, output ready);
endinterface

`default_nettype wire

### hdl/isometric_tile_picker_core.sv
// sequence: a click steps through DIV, REM, EDGE, WRITE and DONE, a read through RADDR,
//   RDATA and DONE; DONE waits for a free output register before loading the result into it
// throughput: one item at a time; no new item is taken until the result leaves DONE
// reset: async, active low; origins go to 0, then a clearing pass over all TILES_X*TILES_Y
//   mark memory entries zeroes them while no item is taken (config writes still taken)
`default_nettype none

module isometric_tile_picker_core
    import itp_pkg::*;
#(
    parameter int CELL_W  = CELL_W_DEF,
    parameter int CELL_H  = CELL_H_DEF,
    parameter int TILES_X = TILES_X_DEF,
    parameter int TILES_Y = TILES_Y_DEF
)(
    input wire            clk,
    input wire            rst_n,
    itp_cfg_if.sink       cfg,
    itp_item_if.sink      items,
    itp_result_if.source  results
);

    localparam int NUM_TILES = TILES_X * TILES_Y;
    localparam int AW        = $clog2(NUM_TILES);
    localparam int LG_W      = $clog2(CELL_W);
    localparam int LG_H      = $clog2(CELL_H);
    localparam int SH_X      = DIV_W + LG_W;
    localparam int SH_Y      = DIV_W + LG_H;
    localparam int MW        = DIV_W + 2;
    localparam int PW        = DIV_W + MW;
    localparam int TW        = DIV_W + 2;
    localparam int LW        = 20;
    localparam int KX        = (POS_SPAN + CELL_W - 1) / CELL_W;
    localparam int KY        = (POS_SPAN + CELL_H - 1) / CELL_H;

    localparam logic [DIV_W-1:0] BIAS_X  = DIV_W'(KX * CELL_W);
    localparam logic [DIV_W-1:0] BIAS_Y  = DIV_W'(KY * CELL_H);
    localparam logic [MW-1:0]    RECIP_X = MW'(((longint'(1) << SH_X) + CELL_W - 1) / CELL_W);
    localparam logic [MW-1:0]    RECIP_Y = MW'(((longint'(1) << SH_Y) + CELL_H - 1) / CELL_H);

    localparam logic signed [LW-1:0] WH  = LW'(CELL_W * CELL_H);
    localparam logic signed [LW-1:0] HWH = LW'((CELL_W / 2) * CELL_H);
    localparam logic signed [LW-1:0] HHW = LW'((CELL_H / 2) * CELL_W);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_REM,
        ST_EDGE,
        ST_WRITE,
        ST_RADDR,
        ST_RDATA,
        ST_DONE
    } state_t;

    state_t state_reg;
    logic [AW-1:0] clr_reg;

    logic [POS_W-1:0] origin_x_reg;
    logic [POS_W-1:0] origin_y_reg;

    // datapath stage registers
    logic [DIV_W-1:0]       ux_reg, uy_reg;
    logic [DIV_W-1:0]       qx_reg, qy_reg;
    logic [LG_W-1:0]        ex_reg;
    logic [LG_H-1:0]        ey_reg;
    logic signed [TW-1:0]   bx_reg, by_reg;
    logic                   hit_reg;
    corner_t                corner_reg;
    logic signed [TW-1:0]   tx_reg, ty_reg;
    logic                   tgt_ok_reg;
    logic [AW-1:0]          rd_addr_reg;
    logic                   q_ok_reg;
    logic [COORD_W-1:0]     query_x_reg, query_y_reg;
    logic                   rd_data_reg;

    // finished result waiting for the output register
    logic               res_hit_reg;
    logic [COORD_W-1:0] res_base_x_reg, res_base_y_reg;
    corner_t            res_corner_reg;
    logic [COORD_W-1:0] res_tx_reg, res_ty_reg;
    logic               res_marked_reg;

    // output register
    logic               out_valid_reg;
    logic               out_hit_reg;
    logic [COORD_W-1:0] out_base_x_reg, out_base_y_reg;
    corner_t            out_corner_reg;
    logic [COORD_W-1:0] out_tx_reg, out_ty_reg;
    logic               out_marked_reg;

    logic mark_mem [NUM_TILES];

    logic               accept;
    logic               q_ok_next;
    logic [AW-1:0]      rd_addr_next;
    logic [DIV_W-1:0]   ux_next, uy_next;
    logic [PW-1:0]      prod_x, prod_y;
    logic [DIV_W-1:0]   rem_x, rem_y;
    logic signed [TW-1:0] cx, cy, bx_next, by_next;
    logic               hit_next;
    logic signed [LW-1:0] ex_h, ey_w;
    logic               left, top;
    logic               in_diamond;
    corner_t            corner_next;
    logic signed [TW-1:0] tx_next, ty_next;
    logic               tgt_ok_next;
    logic [AW-1:0]      wr_addr;
    logic               mem_we, mem_wdata, mem_re;
    logic [AW-1:0]      mem_waddr;
    logic               out_free;

    assign cfg.ready   = 1'b1;
    assign items.ready = (state_reg == ST_IDLE);
    assign accept      = items.valid && items.ready;
    assign out_free    = !out_valid_reg || results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_ORIGIN_X)
                origin_x_reg <= cfg.data;
            else if (cfg.index == REG_ORIGIN_Y)
                origin_y_reg <= cfg.data;
        end
    end

    // accept: bias the offset so the floor division works on positive values
    assign ux_next = DIV_W'(items.pos_x) + BIAS_X - DIV_W'(origin_x_reg);
    assign uy_next = DIV_W'(items.pos_y) + BIAS_Y - DIV_W'(origin_y_reg);
    assign q_ok_next = (int'(items.query_x) < TILES_X) && (int'(items.query_y) < TILES_Y);
    assign rd_addr_next = AW'(items.query_x) * AW'(TILES_Y) + AW'(items.query_y);

    // divide by cell size through reciprocal multiply
    assign prod_x = PW'(ux_reg) * PW'(RECIP_X);
    assign prod_y = PW'(uy_reg) * PW'(RECIP_Y);

    // remainder and coarse iso cell
    assign rem_x   = ux_reg - DIV_W'(qx_reg * DIV_W'(CELL_W));
    assign rem_y   = uy_reg - DIV_W'(qy_reg * DIV_W'(CELL_H));
    assign cx      = signed'(TW'(qx_reg)) - signed'(TW'(KX));
    assign cy      = signed'(TW'(qy_reg)) - signed'(TW'(KY));
    assign bx_next = cy + cx;
    assign by_next = cy - cx;
    assign hit_next = !bx_next[TW-1] && (bx_next < signed'(TW'(TILES_X)))
                   && !by_next[TW-1] && (by_next < signed'(TW'(TILES_Y)));

    // quadrant and diamond edge test, scaled to integers
    assign ex_h = signed'(LW'(ex_reg) * LW'(CELL_H));
    assign ey_w = signed'(LW'(ey_reg) * LW'(CELL_W));
    assign left = {ex_reg, 1'b0} < (LG_W + 1)'(CELL_W);
    assign top  = {ey_reg, 1'b0} < (LG_H + 1)'(CELL_H);

    always_comb
    begin
        in_diamond  = 1'b1;
        corner_next = CORNER_INSIDE;
        tx_next     = bx_reg;
        ty_next     = by_reg;
        unique case ({left, top})
            2'b11:
            begin
                in_diamond = (WH - (ey_w <<< 1)) <= (ex_h <<< 1);
                if (!in_diamond)
                begin
                    corner_next = CORNER_LT;
                    tx_next     = bx_reg - signed'(TW'(1));
                end
            end
            2'b01:
            begin
                in_diamond = ey_w >= (ex_h - HWH);
                if (!in_diamond)
                begin
                    corner_next = CORNER_RT;
                    ty_next     = by_reg - signed'(TW'(1));
                end
            end
            2'b10:
            begin
                in_diamond = (ey_w - HHW) <= ex_h;
                if (!in_diamond)
                begin
                    corner_next = CORNER_LB;
                    ty_next     = by_reg + signed'(TW'(1));
                end
            end
            default:
            begin
                in_diamond = (WH - ((ey_w - HHW) <<< 1)) >= ((ex_h - HWH) <<< 1);
                if (!in_diamond)
                begin
                    corner_next = CORNER_RB;
                    tx_next     = bx_reg + signed'(TW'(1));
                end
            end
        endcase
    end

    assign tgt_ok_next = !tx_next[TW-1] && (tx_next < signed'(TW'(TILES_X)))
                      && !ty_next[TW-1] && (ty_next < signed'(TW'(TILES_Y)));

    assign wr_addr = AW'(tx_reg) * AW'(TILES_Y) + AW'(ty_reg);

    // memory port control
    assign mem_we    = (state_reg == ST_CLEAR)
                    || ((state_reg == ST_WRITE) && hit_reg && tgt_ok_reg);
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_reg : wr_addr;
    assign mem_wdata = (state_reg != ST_CLEAR);
    assign mem_re    = (state_reg == ST_RADDR);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mark_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mark_mem[rd_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ux_reg      <= ux_next;
                    uy_reg      <= uy_next;
                    query_x_reg <= items.query_x;
                    query_y_reg <= items.query_y;
                    q_ok_reg    <= q_ok_next;
                    rd_addr_reg <= rd_addr_next;
                end
            end
            ST_DIV:
            begin
                qx_reg <= DIV_W'(prod_x >> SH_X);
                qy_reg <= DIV_W'(prod_y >> SH_Y);
            end
            ST_REM:
            begin
                ex_reg  <= LG_W'(rem_x);
                ey_reg  <= LG_H'(rem_y);
                bx_reg  <= bx_next;
                by_reg  <= by_next;
                hit_reg <= hit_next;
            end
            ST_EDGE:
            begin
                corner_reg <= corner_next;
                tx_reg     <= tx_next;
                ty_reg     <= ty_next;
                tgt_ok_reg <= tgt_ok_next;
            end
            ST_WRITE:
            begin
                // a miss outside the grid reports all zero
                res_hit_reg    <= hit_reg;
                res_base_x_reg <= hit_reg ? COORD_W'(bx_reg) : '0;
                res_base_y_reg <= hit_reg ? COORD_W'(by_reg) : '0;
                res_corner_reg <= hit_reg ? corner_reg : CORNER_INSIDE;
                res_tx_reg     <= hit_reg ? COORD_W'(tx_reg) : '0;
                res_ty_reg     <= hit_reg ? COORD_W'(ty_reg) : '0;
                res_marked_reg <= hit_reg && tgt_ok_reg;
            end
            ST_RDATA:
            begin
                res_hit_reg    <= 1'b1;
                res_base_x_reg <= '0;
                res_base_y_reg <= '0;
                res_corner_reg <= CORNER_INSIDE;
                res_tx_reg     <= query_x_reg;
                res_ty_reg     <= query_y_reg;
                res_marked_reg <= q_ok_reg && rd_data_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_hit_reg    <= 1'b0;
            out_base_x_reg <= '0;
            out_base_y_reg <= '0;
            out_corner_reg <= CORNER_INSIDE;
            out_tx_reg     <= '0;
            out_ty_reg     <= '0;
            out_marked_reg <= 1'b0;
        end
        else
        begin
            if (results.ready && !((state_reg == ST_DONE) && out_free))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(NUM_TILES - 1))
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (accept)
                        state_reg <= (items.op == OP_READ) ? ST_RADDR : ST_DIV;
                end
                ST_DIV:   state_reg <= ST_REM;
                ST_REM:   state_reg <= ST_EDGE;
                ST_EDGE:  state_reg <= ST_WRITE;
                ST_WRITE: state_reg <= ST_DONE;
                ST_RADDR: state_reg <= ST_RDATA;
                ST_RDATA: state_reg <= ST_DONE;
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_hit_reg    <= res_hit_reg;
                        out_base_x_reg <= res_base_x_reg;
                        out_base_y_reg <= res_base_y_reg;
                        out_corner_reg <= res_corner_reg;
                        out_tx_reg     <= res_tx_reg;
                        out_ty_reg     <= res_ty_reg;
                        out_marked_reg <= res_marked_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign results.valid    = out_valid_reg;
    assign results.hit      = out_hit_reg;
    assign results.base_x   = out_base_x_reg;
    assign results.base_y   = out_base_y_reg;
    assign results.corner   = out_corner_reg;
    assign results.target_x = out_tx_reg;
    assign results.target_y = out_ty_reg;
    assign results.marked   = out_marked_reg;

endmodule

`default_nettype wire

### hdl/itp_checker.sv
`default_nettype none

module itp_checker
    import itp_pkg::*;
(
    input wire                clk,
    input wire                rst_n,
    input wire                in_valid,
    input wire                in_ready,
    input wire                out_valid,
    input wire                out_ready,
    input wire                hit,
    input wire [COORD_W-1:0]  base_x,
    input wire [COORD_W-1:0]  base_y,
    input wire [CORNER_W-1:0] corner,
    input wire [COORD_W-1:0]  target_x,
    input wire [COORD_W-1:0]  target_y,
    input wire                marked
);

    // one item in flight: input closes right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready stayed high after an accepted item");

    // a click that misses the grid reports nothing else
    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !hit) |-> (base_x == '0 && base_y == '0 && corner == CORNER_INSIDE
                                 && target_x == '0 && target_y == '0 && !marked))
        else $error("miss result carries nonzero fields");

    a_corner_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (corner <= CORNER_RB && (corner == CORNER_INSIDE || hit)))
        else $error("corner code out of range or without hit");

    a_marked_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && marked) |-> hit)
        else $error("marked result without hit");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(hit) && $stable(base_x)
            && $stable(base_y) && $stable(corner) && $stable(target_x)
            && $stable(target_y) && $stable(marked)))
        else $error("stalled result changed");

endmodule

bind isometric_tile_picker_core itp_checker u_itp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .hit       (results.hit),
    .base_x    (results.base_x),
    .base_y    (results.base_y),
    .corner    (results.corner),
    .target_x  (results.target_x),
    .target_y  (results.target_y),
    .marked    (results.marked)
);

`default_nettype wire

### tb/tb.sv
module tb;
    import itp_pkg::*;

    localparam int CELL_W  = CELL_W_DEF;
    localparam int CELL_H  = CELL_H_DEF;
    localparam int TILES_X = TILES_X_DEF;
    localparam int TILES_Y = TILES_Y_DEF;
    localparam int HALF_W  = CELL_W / 2;
    localparam int HALF_H  = CELL_H / 2;

    // indexes the block does not decode
    localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = 4'd15;

    localparam int SETTLE_CYCLES = 10;
    localparam int STALL_LIMIT   = 4000;
    localparam int MAX_REPORTS   = 100;

    typedef struct {
        op_t                op;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [COORD_W-1:0] query_x;
        logic [COORD_W-1:0] query_y;
    } pointer_event_t;

    typedef struct {
        logic               hit;
        logic [COORD_W-1:0] base_x;
        logic [COORD_W-1:0] base_y;
        corner_t            corner;
        logic [COORD_W-1:0] target_x;
        logic [COORD_W-1:0] target_y;
        logic               marked;
    } pick_result_t;

    logic clk;
    logic rst_n;

    itp_cfg_if    cfg_ch();
    itp_item_if   item_ch();
    itp_result_if result_ch();

    isometric_tile_picker_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .items   (item_ch),
        .results (result_ch)
    );

    // own copy of the registers and the tile bitmap
    logic [POS_W-1:0] org_x;
    logic [POS_W-1:0] org_y;
    bit               marks [TILES_X*TILES_Y];

    pointer_event_t event_queue [$];
    pick_result_t   expected_picks [$];
    pointer_event_t cur_event;
    pick_result_t   want_pick;
    bit             event_busy;
    int             send_idle;
    int             send_calm;
    int             recv_idle;
    int             recv_calm;
    int             mismatches;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int idle_len(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm = calm - 1;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic int floor_div(int num, int den);
        int q;
        q = num / den;
        if (num % den != 0 && num < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic bit in_grid(int x, int y);
        return x >= 0 && x < TILES_X && y >= 0 && y < TILES_Y;
    endfunction

    // computes the result of one item and updates the bitmap
    function automatic pick_result_t pick_tile(pointer_event_t ev);
        pick_result_t res;
        int           cx, cy, bx, by, tx, ty, ex, ey;
        bit           left, top, in_diamond;
        corner_t      quad;
        res.hit      = 1'b0;
        res.base_x   = '0;
        res.base_y   = '0;
        res.corner   = CORNER_INSIDE;
        res.target_x = '0;
        res.target_y = '0;
        res.marked   = 1'b0;
        if (ev.op == OP_READ)
        begin
            res.hit      = 1'b1;
            res.target_x = ev.query_x;
            res.target_y = ev.query_y;
            if (in_grid(int'(ev.query_x), int'(ev.query_y)))
                res.marked = marks[int'(ev.query_x) * TILES_Y + int'(ev.query_y)];
            return res;
        end
        cx = floor_div(int'(ev.pos_x) - int'(org_x), CELL_W);
        cy = floor_div(int'(ev.pos_y) - int'(org_y), CELL_H);
        bx = cx + cy;
        by = cy - cx;
        if (!in_grid(bx, by))
            return res;
        ex   = int'(ev.pos_x) - (int'(org_x) + cx * CELL_W);
        ey   = int'(ev.pos_y) - (int'(org_y) + cy * CELL_H);
        left = 2 * ex < CELL_W;
        top  = 2 * ey < CELL_H;
        // edge tests scaled to whole numbers, points on the edge are inside
        if (left && top)
        begin
            quad       = CORNER_LT;
            in_diamond = CELL_W * CELL_H - 2 * ey * CELL_W <= 2 * ex * CELL_H;
        end
        else if (top)
        begin
            quad       = CORNER_RT;
            in_diamond = ey * CELL_W >= (ex - HALF_W) * CELL_H;
        end
        else if (left)
        begin
            quad       = CORNER_LB;
            in_diamond = (ey - HALF_H) * CELL_W <= ex * CELL_H;
        end
        else
        begin
            quad       = CORNER_RB;
            in_diamond = CELL_W * CELL_H - 2 * (ey - HALF_H) * CELL_W
                         >= 2 * (ex - HALF_W) * CELL_H;
        end
        if (in_diamond)
            quad = CORNER_INSIDE;
        tx = bx;
        ty = by;
        case (quad)
            CORNER_LT: tx = tx - 1;
            CORNER_RT: ty = ty - 1;
            CORNER_LB: ty = ty + 1;
            CORNER_RB: tx = tx + 1;
            default:   ;
        endcase
        if (in_grid(tx, ty))
        begin
            marks[tx * TILES_Y + ty] = 1'b1;
            res.marked = 1'b1;
        end
        res.hit      = 1'b1;
        res.base_x   = COORD_W'(bx);
        res.base_y   = COORD_W'(by);
        res.corner   = quad;
        res.target_x = COORD_W'(tx);
        res.target_y = COORD_W'(ty);
        return res;
    endfunction

    function automatic pointer_event_t random_event();
        pointer_event_t ev;
        int             r, bx, by, px, py;
        r          = $urandom_range(0, 99);
        ev.op      = OP_CLICK;
        ev.pos_x   = POS_W'($urandom);
        ev.pos_y   = POS_W'($urandom);
        ev.query_x = COORD_W'($urandom);
        ev.query_y = COORD_W'($urandom);
        if (r < 30)
            ev.op = OP_READ;
        else if (r < 85)
        begin
            // aim at a grid tile; iso coords of one coarse cell share parity
            bx = $urandom_range(0, TILES_X - 1);
            by = $urandom_range(0, TILES_Y - 1);
            if (((bx ^ by) & 1) != 0)
                by = by ^ 1;
            px = int'(org_x) + ((bx - by) / 2) * CELL_W + int'($urandom_range(0, CELL_W - 1));
            py = int'(org_y) + ((bx + by) / 2) * CELL_H + int'($urandom_range(0, CELL_H - 1));
            if (px >= 0 && px < POS_SPAN && py >= 0 && py < POS_SPAN)
            begin
                ev.pos_x = POS_W'(px);
                ev.pos_y = POS_W'(py);
            end
        end
        return ev;
    endfunction

    task automatic push_click(int x, int y);
        pointer_event_t ev;
        ev.op      = OP_CLICK;
        ev.pos_x   = POS_W'(x);
        ev.pos_y   = POS_W'(y);
        ev.query_x = COORD_W'($urandom);
        ev.query_y = COORD_W'($urandom);
        event_queue.push_back(ev);
    endtask

    task automatic push_read(int qx, int qy);
        pointer_event_t ev;
        ev.op      = OP_READ;
        ev.pos_x   = POS_W'($urandom);
        ev.pos_y   = POS_W'($urandom);
        ev.query_x = COORD_W'(qx);
        ev.query_y = COORD_W'(qy);
        event_queue.push_back(ev);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_ORIGIN_X)
            org_x = value;
        else if (idx == REG_ORIGIN_Y)
            org_y = value;
    endtask

    // all items sent and all results back, then let the pipeline settle
    task automatic wait_idle();
        while (event_queue.size() != 0 || event_busy || expected_picks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch %s: got %0h want %0h", what, got, want);
    endtask

    task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // item driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                expected_picks.push_back(pick_tile(cur_event));
                event_busy = 1'b0;
            end
            if (!event_busy)
            begin
                if (send_idle > 0)
                begin
                    send_idle = send_idle - 1;
                    item_ch.valid <= 1'b0;
                end
                else if (event_queue.size() != 0)
                begin
                    cur_event  = event_queue.pop_front();
                    event_busy = 1'b1;
                    item_ch.valid   <= 1'b1;
                    item_ch.op      <= cur_event.op;
                    item_ch.pos_x   <= cur_event.pos_x;
                    item_ch.pos_y   <= cur_event.pos_y;
                    item_ch.query_x <= cur_event.query_x;
                    item_ch.query_y <= cur_event.query_y;
                    send_idle = idle_len(send_calm);
                end
                else
                    item_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_picks.size() == 0)
                    report_mismatch("result with no item pending", 32'd1, 32'd0);
                else
                begin
                    want_pick = expected_picks.pop_front();
                    check_field("hit", 32'(result_ch.hit), 32'(want_pick.hit));
                    check_field("base_x", 32'(result_ch.base_x), 32'(want_pick.base_x));
                    check_field("base_y", 32'(result_ch.base_y), 32'(want_pick.base_y));
                    check_field("corner", 32'(result_ch.corner), 32'(want_pick.corner));
                    check_field("target_x", 32'(result_ch.target_x),
                                32'(want_pick.target_x));
                    check_field("target_y", 32'(result_ch.target_y),
                                32'(want_pick.target_y));
                    check_field("marked", 32'(result_ch.marked), 32'(want_pick.marked));
                end
            end
            if (recv_idle > 0)
            begin
                recv_idle = recv_idle - 1;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                recv_idle = idle_len(recv_calm);
            end
        end
    end

    // watchdog on cycles without any handshake
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (cfg_ch.valid && cfg_ch.ready) || (item_ch.valid && item_ch.ready)
                || (result_ch.valid && result_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int ox, oy, n;
        rst_n           = 1'b0;
        org_x           = '0;
        org_y           = '0;
        event_busy      = 1'b0;
        send_idle       = 0;
        send_calm       = 0;
        recv_idle       = 0;
        recv_calm       = 0;
        mismatches      = 0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = REG_ORIGIN_X;
        cfg_ch.data     = '0;
        item_ch.valid   = 1'b0;
        item_ch.op      = OP_CLICK;
        item_ch.pos_x   = '0;
        item_ch.pos_y   = '0;
        item_ch.query_x = '0;
        item_ch.query_y = '0;
        result_ch.ready = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // writes land during the bitmap clearing pass
        write_reg(REG_ORIGIN_X, '0);
        write_reg(REG_ORIGIN_Y, '0);
        write_reg(REG_NONE_HI, '1);

        // cleared bitmap at both far corners
        push_read(0, 0);
        push_read(TILES_X - 1, TILES_Y - 1);
        // left-top corner of the first cell steps off the grid
        push_click(0, 0);
        push_click(HALF_W, HALF_H);
        // coarse cell outside the grid
        push_click(POS_SPAN - 1, POS_SPAN - 1);
        push_click(POS_SPAN - 1, 0);
        // each corner of the cell at iso (7,3), then points on the edges
        push_click(2 * CELL_W, 5 * CELL_H);
        push_click(3 * CELL_W - 1, 5 * CELL_H);
        push_click(2 * CELL_W, 6 * CELL_H - 1);
        push_click(3 * CELL_W - 1, 6 * CELL_H - 1);
        push_click(2 * CELL_W + HALF_W / 2, 5 * CELL_H + HALF_H / 2);
        push_click(2 * CELL_W + HALF_W, 5 * CELL_H);
        push_click(2 * CELL_W + HALF_W, 5 * CELL_H + HALF_H);
        // iso (15,15): right and bottom neighbours fall off the grid
        push_click(CELL_W - 1, 16 * CELL_H - 1);
        push_click(0, 16 * CELL_H - 1);
        push_read(6, 3);
        push_read(7, 2);
        push_read(7, 4);
        push_read(8, 3);
        push_read(7, 3);
        push_read(0, 0);
        push_read(TILES_X - 1, 0);
        push_read(0, TILES_Y - 1);

        for (int p = 0; p < 9; p++)
        begin
            wait_idle();
            case (p)
                0:
                begin
                    ox = POS_SPAN - 1;
                    oy = POS_SPAN - 1;
                end
                1:
                begin
                    ox = 0;
                    oy = POS_SPAN - 1;
                end
                2:
                begin
                    ox = POS_SPAN - 1;
                    oy = 0;
                end
                default:
                begin
                    ox = $urandom_range(0, 2047);
                    oy = $urandom_range(0, 2047);
                end
            endcase
            write_reg(REG_ORIGIN_X, POS_W'(ox));
            write_reg(REG_ORIGIN_Y, POS_W'(oy));
            if (p == 4)
            begin
                write_reg(REG_NONE_LO, POS_W'($urandom));
                write_reg(REG_NONE_HI, POS_W'($urandom));
            end
            n = (p < 3) ? 30 : 60;
            repeat (n) event_queue.push_back(random_event());
        end

        wait_idle();
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### sim.f
hdl/itp_pkg.sv
hdl/itp_channels.sv
hdl/isometric_tile_picker_core.sv
hdl/itp_checker.sv
tb/tb.sv
